FILE: rtl/core/lkb32_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkb32_pkg
// Types and constants shared by the license key base32 decoder.
// ---------------------------------------------------------------------------
package lkb32_pkg;

    localparam int KEY_CHARS    = 71;
    localparam int GROUP_SPAN   = 6;
    localparam int SYMBOL_BITS  = 5;
    localparam int DIGIT_OFFSET = 26;
    localparam int BYTE_BITS    = 8;
    localparam int BYTE_COUNT_MAX = 63;

    localparam logic [7:0] VERSION_BYTE = 8'h01;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_SEVEN   = 8'h37;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FORMAT  = 2'd1,
        STATUS_VERSION = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_key;
    } key_char_t;

    typedef struct packed {
        logic [31:0] word;
        logic [3:0]  word_index;
        logic        word_valid;
        logic        done_res;
        status_t     status;
    } key_word_t;

    typedef struct packed {
        logic [6:0]  char_pos;
        logic [2:0]  group_pos;
        logic [7:0]  acc;
        logic [3:0]  bits_free;
        logic [5:0]  byte_count;
        logic [31:0] word_shift;
        logic        format_error;
        logic        version_error;
    } dec_state_t;

    localparam dec_state_t STATE_RESET = '{
        char_pos:      7'd0,
        group_pos:     3'd0,
        acc:           8'd0,
        bits_free:     4'd8,
        byte_count:    6'd0,
        word_shift:    32'd0,
        format_error:  1'b0,
        version_error: 1'b0
    };

endpackage

FILE: rtl/core/lkb32_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkb32_stream_if
// Valid/ready channel carrying one item per handshake.
// ---------------------------------------------------------------------------
interface lkb32_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

FILE: rtl/core/lkb32_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkb32_step
// Per-character decode: format check, base32 bit packing and word assembly.
// ---------------------------------------------------------------------------
module lkb32_step (
    input  lkb32_pkg::dec_state_t state,
    input  lkb32_pkg::key_char_t  item,
    output lkb32_pkg::dec_state_t state_next,
    output lkb32_pkg::key_word_t  result,
    output logic                  has_result
);
    import lkb32_pkg::*;

    logic       sym_ok;
    logic [4:0] sym_val;
    logic [7:0] sym_byte;
    logic [7:0] byte_out;
    logic [3:0] sh_up;
    logic [3:0] sh_down;
    logic [3:0] sh_fill;
    logic       have_word;
    logic [3:0] index_out;
    dec_state_t nxt;

    always_comb
    begin
        sym_ok  = 1'b0;
        sym_val = 5'd0;
        if (item.ch >= CHAR_UPPER_A && item.ch <= CHAR_UPPER_Z)
        begin
            sym_ok  = 1'b1;
            sym_val = 5'(item.ch - CHAR_UPPER_A);
        end
        else if (item.ch >= CHAR_TWO && item.ch <= CHAR_SEVEN)
        begin
            sym_ok  = 1'b1;
            sym_val = 5'(item.ch - CHAR_TWO + 8'(DIGIT_OFFSET));
        end
    end

    assign sym_byte = {3'b000, sym_val};
    assign sh_up    = state.bits_free - 4'(SYMBOL_BITS);
    assign sh_down  = 4'(SYMBOL_BITS) - state.bits_free;
    assign sh_fill  = 4'(BYTE_BITS - SYMBOL_BITS) + state.bits_free;
    assign byte_out = state.acc | (sym_byte >> sh_down);

    always_comb
    begin
        nxt       = state;
        have_word = 1'b0;
        index_out = 4'd0;

        if (state.char_pos >= 7'(KEY_CHARS))
        begin
            nxt.format_error = 1'b1;
        end
        else if (state.group_pos == 3'(GROUP_SPAN - 1))
        begin
            if (item.ch != CHAR_DASH)
            begin
                nxt.format_error = 1'b1;
            end
        end
        else if (!sym_ok)
        begin
            nxt.format_error = 1'b1;
        end
        else if (!state.format_error && !state.version_error)
        begin
            if (state.bits_free > 4'(SYMBOL_BITS))
            begin
                nxt.acc       = state.acc | (sym_byte << sh_up);
                nxt.bits_free = sh_up;
            end
            else
            begin
                nxt.acc       = sym_byte << sh_fill;
                nxt.bits_free = state.bits_free + 4'(BYTE_BITS - SYMBOL_BITS);
                if (state.byte_count == 6'd0)
                begin
                    if (byte_out != VERSION_BYTE)
                    begin
                        nxt.version_error = 1'b1;
                    end
                end
                else
                begin
                    nxt.word_shift = {state.word_shift[23:0], byte_out};
                    if (state.byte_count[1:0] == 2'b00)
                    begin
                        have_word = 1'b1;
                        index_out = state.byte_count[5:2] - 4'd1;
                    end
                end
                if (state.byte_count < 6'(BYTE_COUNT_MAX))
                begin
                    nxt.byte_count = state.byte_count + 6'd1;
                end
            end
        end

        if (state.char_pos < 7'(KEY_CHARS))
        begin
            nxt.char_pos  = state.char_pos + 7'd1;
            nxt.group_pos = (state.group_pos == 3'(GROUP_SPAN - 1)) ?
                            3'd0 : state.group_pos + 3'd1;
        end

        if (item.end_of_key && state.char_pos != 7'(KEY_CHARS - 1))
        begin
            nxt.format_error = 1'b1;
        end

        if (nxt.format_error)
        begin
            have_word = 1'b0;
            index_out = 4'd0;
        end

        has_result        = have_word || item.end_of_key;
        result.word       = have_word ? nxt.word_shift : 32'd0;
        result.word_index = index_out;
        result.word_valid = have_word;
        result.done_res   = item.end_of_key;
        if (!item.end_of_key)
        begin
            result.status = STATUS_OK;
        end
        else if (nxt.format_error)
        begin
            result.status = STATUS_FORMAT;
        end
        else if (nxt.version_error)
        begin
            result.status = STATUS_VERSION;
        end
        else
        begin
            result.status = STATUS_OK;
        end

        state_next = item.end_of_key ? STATE_RESET : nxt;
    end

endmodule

FILE: rtl/core/license_key_base32_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// license_key_base32_decoder
// Streams a dashed base32 license key in and key words plus a status out.
// ---------------------------------------------------------------------------
// key_chars carries one ASCII character per item, end_of_key set on the last
// one. A well-formed key is twelve groups of five symbols joined by dashes.
// dec_words carries at most one item per character: a completed 32-bit word
// (index 0 is the feature id, 1..8 key words) and/or, for the end-of-key
// character, the status (ok, bad format or length, bad version byte).
// Characters that complete no word and do not end the key give no item.
// A character is captured in the input register, decoded by the combinational step
// logic, and its result is captured in the output register, which drives dec_words.
// Throughput: one character per cycle unless the receiver stalls; the bit packing
// and word shift state updates as each character is decoded.
// If the receiver stalls, the output register holds its item and the input
// register still takes one more character; characters that give no result
// keep flowing through, a result-bearing one waits in the input register.
// Reset marks both registers empty and returns the decoder to the start of a key;
// the end-of-key character also returns it there.
// ---------------------------------------------------------------------------
module license_key_base32_decoder (
    input logic             clk,
    input logic             rst_n,
    lkb32_stream_if.sink    key_chars,
    lkb32_stream_if.source  dec_words
);
    import lkb32_pkg::*;

    logic       in_valid_reg;
    key_char_t  in_item_reg;
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    key_word_t  out_item_reg;
    key_word_t  step_result;
    logic       step_has_result;
    logic       advance;

    lkb32_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step_result),
        .has_result (step_has_result)
    );

    assign advance = in_valid_reg &&
                     (!step_has_result || !out_valid_reg || dec_words.ready);
    assign key_chars.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance && step_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (dec_words.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (key_chars.ready)
            begin
                in_valid_reg <= key_chars.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_chars.valid && key_chars.ready)
        begin
            in_item_reg <= key_chars.data;
        end
        if (advance && step_has_result)
        begin
            out_item_reg <= step_result;
        end
    end

    assign dec_words.valid = out_valid_reg;
    assign dec_words.data  = out_item_reg;

`ifndef SYNTHESIS
    // words only ever carry indexes 0..8
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.word_valid |-> out_item_reg.word_index <= 4'd8)
        else $error("word index out of range");

    // status is only reported with the end-of-key item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.done_res |-> out_item_reg.status == STATUS_OK)
        else $error("status without end of key");

    // bit packer always has between one and eight free bits
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bits_free != 4'd0 && state_reg.bits_free <= 4'd8)
        else $error("bits_free out of range");

    // position saturates just past a full key
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.char_pos <= 7'(KEY_CHARS))
        else $error("char position overrun");

    // the end-of-key item returns the decoder to the start of a key
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.end_of_key |=> state_reg == STATE_RESET)
        else $error("decoder not reset after end of key");
`endif

endmodule

FILE: test/license_key_base32_decoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// license_key_base32_decoder_tb
// Streams dashed base32 keys, good and broken, through the decoder with
// random stalls on both channels. Every key word and status item is checked
// field by field against a cycle-free decode of the same characters.
// ---------------------------------------------------------------------------
module license_key_base32_decoder_tb;
    import lkb32_pkg::*;

    typedef struct {
        key_char_t c;
        bit        drain;
    } pend_char_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_VERSION,
        FLAW_CHAR,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_BOTH
    } flaw_t;

    localparam int TARGET_ITEMS = 1900;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;

    lkb32_stream_if #(.T(key_char_t)) key_chars ();
    lkb32_stream_if #(.T(key_word_t)) dec_words ();

    license_key_base32_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_chars (key_chars),
        .dec_words (dec_words)
    );

    pend_char_t char_q[$];
    key_word_t  word_q[$];

    // decoder image
    logic [6:0]  dec_pos;
    logic [7:0]  dec_acc;
    logic [3:0]  dec_free;
    logic [5:0]  dec_nbytes;
    logic [31:0] dec_shreg;
    bit          dec_fmt_err;
    bit          dec_ver_err;

    int  tx_gap;
    int  rx_gap;
    bit  tx_quiet;
    bit  rx_quiet;
    bit  rx_hold = 1'b0;
    int  sent_count;
    int  mismatches;
    int  built_items;

    task automatic clear_decoder();
        dec_pos     = '0;
        dec_acc     = '0;
        dec_free    = 4'd8;
        dec_nbytes  = '0;
        dec_shreg   = '0;
        dec_fmt_err = 1'b0;
        dec_ver_err = 1'b0;
    endtask

    task automatic decode_char(input key_char_t c);
        logic [6:0] p;
        logic [4:0] v;
        logic [7:0] v8;
        logic [7:0] b;
        bit         is_sym;
        bit         got_word;
        key_word_t  r;
        p        = dec_pos;
        got_word = 1'b0;
        is_sym   = 1'b1;
        v        = '0;
        r        = '{word: '0, word_index: '0, word_valid: 1'b0, done_res: 1'b0,
                     status: STATUS_OK};
        if (c.ch >= CHAR_UPPER_A && c.ch <= CHAR_UPPER_Z)
            v = 5'(c.ch - CHAR_UPPER_A);
        else if (c.ch >= CHAR_TWO && c.ch <= CHAR_SEVEN)
            v = 5'(c.ch - CHAR_TWO + DIGIT_OFFSET);
        else
            is_sym = 1'b0;
        v8 = {3'b000, v};
        if (p >= KEY_CHARS)
            dec_fmt_err = 1'b1;
        else if (p % GROUP_SPAN == GROUP_SPAN - 1)
        begin
            if (c.ch != CHAR_DASH)
                dec_fmt_err = 1'b1;
        end
        else if (!is_sym)
            dec_fmt_err = 1'b1;
        else if (!dec_fmt_err && !dec_ver_err)
        begin
            if (dec_free > SYMBOL_BITS)
            begin
                dec_acc  = dec_acc | (v8 << (dec_free - SYMBOL_BITS));
                dec_free = 4'(dec_free - SYMBOL_BITS);
            end
            else
            begin
                b        = dec_acc | (v8 >> (SYMBOL_BITS - dec_free));
                dec_acc  = v8 << (BYTE_BITS - SYMBOL_BITS + dec_free);
                dec_free = 4'(dec_free + BYTE_BITS - SYMBOL_BITS);
                if (dec_nbytes == 0)
                begin
                    if (b != VERSION_BYTE)
                        dec_ver_err = 1'b1;
                end
                else
                begin
                    dec_shreg = {dec_shreg[23:0], b};
                    if (dec_nbytes[1:0] == 2'd0)
                    begin
                        got_word     = 1'b1;
                        r.word       = dec_shreg;
                        r.word_index = 4'((dec_nbytes >> 2) - 1);
                    end
                end
                if (dec_nbytes < BYTE_COUNT_MAX)
                    dec_nbytes = dec_nbytes + 6'd1;
            end
        end
        if (dec_pos < KEY_CHARS)
            dec_pos = dec_pos + 7'd1;
        if (c.end_of_key && p != KEY_CHARS - 1)
            dec_fmt_err = 1'b1;
        if (got_word && dec_fmt_err)
        begin
            got_word     = 1'b0;
            r.word       = '0;
            r.word_index = '0;
        end
        if (got_word || c.end_of_key)
        begin
            r.word_valid = got_word;
            r.done_res   = c.end_of_key;
            if (c.end_of_key)
            begin
                r.status = dec_fmt_err ? STATUS_FORMAT :
                           (dec_ver_err ? STATUS_VERSION : STATUS_OK);
                clear_decoder();
            end
            word_q = {word_q, r};
        end
    endtask

    task automatic add_char(input logic [7:0] ch, input bit last, input bit drain);
        pend_char_t e;
        e.c.ch         = ch;
        e.c.end_of_key = last;
        e.drain        = drain;
        char_q = {char_q, e};
        built_items++;
    endtask

    task automatic add_key(input flaw_t flaw, input bit drain);
        logic [4:0] sym [60];
        logic [7:0] text [KEY_CHARS];
        int         fill;
        int         k;
        int         len;
        int         spot;
        int         n;
        fill = $urandom_range(0, 7);
        for (int i = 0; i < 60; i++)
            sym[i] = (fill == 0) ? 5'd31 : (fill == 1) ? 5'd0 : 5'($urandom_range(0, 31));
        // version byte 1: symbol 0 is zero, symbol 1 starts with 001
        sym[0] = 5'd0;
        sym[1] = 5'(4 + $urandom_range(0, 3));
        if (flaw == FLAW_VERSION || flaw == FLAW_BOTH)
        begin
            if ($urandom_range(0, 1))
                sym[0] = 5'($urandom_range(1, 31));
            else
            begin
                sym[1] = 5'($urandom_range(0, 31));
                if (sym[1][4:2] == 3'b001)
                    sym[1] = sym[1] + 5'd8;
            end
        end
        k = 0;
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            if (i % GROUP_SPAN == GROUP_SPAN - 1)
                text[i] = CHAR_DASH;
            else
            begin
                text[i] = (sym[k] < DIGIT_OFFSET) ? 8'(CHAR_UPPER_A + sym[k]) :
                          8'(CHAR_TWO + sym[k] - DIGIT_OFFSET);
                k++;
            end
        end
        if (flaw == FLAW_CHAR || flaw == FLAW_BOTH)
        begin
            spot       = $urandom_range(0, KEY_CHARS - 1);
            text[spot] = $urandom_range(0, 1) ? CHAR_DASH : 8'($urandom_range(0, 255));
        end
        len = (flaw == FLAW_SHORT) ? $urandom_range(1, KEY_CHARS - 1) : KEY_CHARS;
        for (int i = 0; i < len; i++)
            add_char(text[i], (i == len - 1) && (flaw != FLAW_LONG), drain && (i == 0));
        if (flaw == FLAW_LONG)
        begin
            n = $urandom_range(1, 4);
            for (int j = 0; j < n; j++)
                add_char($urandom_range(0, 1) ? CHAR_UPPER_A : 8'($urandom_range(0, 255)),
                         j == n - 1, 1'b0);
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        key_chars.valid = 1'b0;
        key_chars.data  = '0;
        dec_words.ready = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender
    always @(posedge clk)
    begin : driver_proc
        pend_char_t nxt;
        bit         offer;
        if (!rst_n)
        begin
            key_chars.valid <= 1'b0;
            key_chars.data  <= '0;
            tx_gap = 0;
            clear_decoder();
        end
        else
        begin
            if (key_chars.valid && key_chars.ready)
            begin
                decode_char(key_chars.data);
                sent_count++;
                if ($urandom_range(0, 63) == 0)
                    tx_quiet = ~tx_quiet;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 5);
            end
            if (!key_chars.valid || key_chars.ready)
            begin
                offer = 1'b0;
                if (tx_gap > 0)
                    tx_gap--;
                else if (char_q.size() > 0 && !(char_q[0].drain && word_q.size() > 0))
                begin
                    nxt   = char_q.pop_front();
                    offer = 1'b1;
                end
                if (offer)
                begin
                    key_chars.valid <= 1'b1;
                    key_chars.data  <= nxt.c;
                end
                else
                    key_chars.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin : monitor_proc
        key_word_t want;
        key_word_t seen;
        if (!rst_n)
        begin
            dec_words.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (dec_words.valid && dec_words.ready)
            begin
                seen = dec_words.data;
                if (word_q.size() == 0)
                begin
                    $error("key word item with nothing expected: word %h index %0d",
                           seen.word, seen.word_index);
                    mismatches++;
                end
                else
                begin
                    want = word_q.pop_front();
                    if (seen.word !== want.word)
                    begin
                        $error("word: expected %h, actual %h", want.word, seen.word);
                        mismatches++;
                    end
                    if (seen.word_index !== want.word_index)
                    begin
                        $error("word_index: expected %0d, actual %0d",
                               want.word_index, seen.word_index);
                        mismatches++;
                    end
                    if (seen.word_valid !== want.word_valid)
                    begin
                        $error("word_valid: expected %b, actual %b",
                               want.word_valid, seen.word_valid);
                        mismatches++;
                    end
                    if (seen.done_res !== want.done_res)
                    begin
                        $error("done_res: expected %b, actual %b",
                               want.done_res, seen.done_res);
                        mismatches++;
                    end
                    if (seen.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, seen.status);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    rx_quiet = ~rx_quiet;
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                dec_words.ready <= 1'b0;
            end
            else
                dec_words.ready <= !rx_hold;
        end
    end

    // long receiver stall while characters keep coming
    initial
    begin
        wait (sent_count >= 400);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus_proc
        int kind;
        int n;
        // single characters and triples: extremes of ch, dashes, near-symbols
        add_char(8'h00, 1'b1, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0);
        add_char(CHAR_UPPER_A, 1'b1, 1'b0);
        add_char(CHAR_UPPER_Z, 1'b1, 1'b0);
        add_char(CHAR_TWO, 1'b1, 1'b0);
        add_char(CHAR_SEVEN, 1'b1, 1'b0);
        add_char(CHAR_DASH, 1'b1, 1'b0);
        add_char(8'h40, 1'b1, 1'b0);
        add_char(8'h5B, 1'b1, 1'b0);
        add_char(8'h31, 1'b1, 1'b0);
        add_char(8'h38, 1'b1, 1'b0);
        add_char(8'h61, 1'b1, 1'b0);
        add_char(CHAR_UPPER_A, 1'b0, 1'b0);
        add_char(CHAR_UPPER_A + 8'd4, 1'b0, 1'b0);
        add_char(CHAR_SEVEN, 1'b1, 1'b0);
        add_char(CHAR_SEVEN, 1'b0, 1'b0);
        add_char(8'hAA, 1'b0, 1'b0);
        add_char(8'h55, 1'b1, 1'b0);
        add_key(FLAW_NONE, 1'b1);
        while (built_items < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1, 2, 3, 4, 5: add_key(FLAW_NONE, $urandom_range(0, 7) == 0);
                6:  add_key(FLAW_VERSION, 1'b0);
                7:  add_key(FLAW_CHAR, 1'b0);
                8:  add_key(FLAW_SHORT, 1'b0);
                9:  add_key(FLAW_LONG, 1'b0);
                10: add_key(FLAW_BOTH, 1'b0);
                default:
                begin
                    n = $urandom_range(1, 8);
                    for (int j = 0; j < n; j++)
                        add_char(8'($urandom_range(0, 255)),
                                 (j == n - 1) || ($urandom_range(0, 15) == 0), 1'b0);
                end
            endcase
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        wait (char_q.size() == 0 && !key_chars.valid);
        wait (word_q.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && word_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/lkb32_pkg.sv
rtl/core/lkb32_stream_if.sv
rtl/core/lkb32_step.sv
rtl/core/license_key_base32_decoder.sv
test/license_key_base32_decoder_tb.sv
